// ----- sv/i2cbs_pkg.sv -----
`default_nettype none
package i2cbs_pkg;

   // Command codes carried in the request
   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_START     = 3'd1,
      CMD_STOP      = 3'd2,
      CMD_WRITE     = 3'd3,
      CMD_READ_ACK  = 3'd4,
      CMD_READ_NACK = 3'd5
   } cmd_type;

   // Bit width of a data byte and the slot that samples or drives the acknowledge
   localparam int unsigned BYTE_BITS = 8;
   localparam logic [3:0]  ACK_SLOT  = 4'd8;
   localparam logic [3:0]  EDGE_SLOT = 4'd1;
   localparam logic [7:0]  MSB_MASK  = 8'h80;

   // Sequencer state carried from slot to slot
   typedef struct packed {
      cmd_type    cmd;
      logic [3:0] slot;
      logic [7:0] shift;
      logic       scl_hold;
      logic       sda_hold;
   } seq_state_type;

   // One request as held in the input register
   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] write_byte;
      logic       sda_sample;
   } slot_req_type;

   // One result item
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       nack_seen;
      logic       cmd_rejected;
   } slot_rsp_type;

endpackage
`default_nettype wire

// ----- sv/i2cbs_slot.sv -----
`default_nettype none
module i2cbs_slot
   import i2cbs_pkg::*;
(
   input  wire seq_state_type state_cur,
   input  wire slot_req_type  req,
   output seq_state_type      state_nxt,
   output slot_rsp_type       rsp
);

   logic       cmd_valid;
   cmd_type    act;
   logic [3:0] slot;
   logic [3:0] last;
   logic [7:0] shift_src;
   logic [7:0] shift_new;
   logic       sda_drv;
   logic       nack;
   logic [7:0] rbyte;

   // Pick up a new command only while idle
   always_comb begin
      cmd_valid = (req.cmd >= 3'd1) && (req.cmd <= 3'd5);
      if (state_cur.cmd == CMD_NONE) begin
         act  = cmd_valid ? cmd_type'(req.cmd) : CMD_NONE;
         slot = '0;
      end else begin
         act  = state_cur.cmd;
         slot = state_cur.slot;
      end
      last = ((act == CMD_START) || (act == CMD_STOP)) ? EDGE_SLOT : ACK_SLOT;
   end

   // Drive the lines for the current slot and advance the shift byte
   always_comb begin
      sda_drv   = state_cur.sda_hold;
      nack      = 1'b0;
      rbyte     = '0;
      shift_src = state_cur.shift;
      shift_new = state_cur.shift;
      case (act)
         CMD_NONE: begin
            sda_drv = state_cur.sda_hold;
         end
         CMD_START: begin
            sda_drv = (slot == '0);
         end
         CMD_STOP: begin
            sda_drv = (slot != '0);
         end
         CMD_WRITE: begin
            shift_src = (slot == '0) ? req.write_byte : state_cur.shift;
            if (slot < ACK_SLOT) begin
               sda_drv   = (shift_src & MSB_MASK) != '0;
               shift_new = {shift_src[BYTE_BITS-2:0], 1'b0};
            end else begin
               sda_drv   = 1'b1;
               nack      = req.sda_sample;
               shift_new = shift_src;
            end
         end
         default: begin
            shift_src = (slot == '0) ? '0 : state_cur.shift;
            if (slot < ACK_SLOT) begin
               sda_drv   = 1'b1;
               shift_new = {shift_src[BYTE_BITS-2:0], req.sda_sample};
            end else begin
               sda_drv   = (act != CMD_READ_ACK);
               rbyte     = shift_src;
               shift_new = shift_src;
            end
         end
      endcase
   end

   // Form the result and the state for the next slot
   always_comb begin
      state_nxt = state_cur;
      rsp.scl_level    = state_cur.scl_hold;
      rsp.sda_level    = state_cur.sda_hold;
      rsp.busy_res     = 1'b0;
      rsp.done_res     = 1'b0;
      rsp.read_byte    = '0;
      rsp.nack_seen    = 1'b0;
      rsp.cmd_rejected = (state_cur.cmd != CMD_NONE) && cmd_valid;
      if (act != CMD_NONE) begin
         rsp.scl_level   = 1'b1;
         rsp.sda_level   = sda_drv;
         rsp.busy_res    = 1'b1;
         rsp.read_byte   = rbyte;
         rsp.nack_seen   = nack;
         state_nxt.shift = shift_new;
         if (slot >= last) begin
            rsp.done_res       = 1'b1;
            state_nxt.scl_hold = (act == CMD_STOP);
            state_nxt.sda_hold = sda_drv;
            state_nxt.cmd      = CMD_NONE;
            state_nxt.slot     = '0;
         end else begin
            state_nxt.cmd  = act;
            state_nxt.slot = slot + 4'd1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- sv/i2c_master_bit_sequencer_unit.sv -----
// Bit-level I2C master sequencer. Each request is one bus timing slot and gives
// exactly one response with the SCL/SDA levels for that slot plus status. One
// request is taken every clock cycle when the response side keeps up; a request
// passes an input register and then a result register, and its response is
// presented from the result register. The rate is set by the combinational slot
// update that feeds the sequencer state (command, slot count, shift byte, held
// levels) back into itself between the two registers.
`default_nettype none
module i2c_master_bit_sequencer_unit
   import i2cbs_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [2:0] cmd, [10:3] write_byte, [11] sda_sample, [15:12] zero
   input  wire  [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
   // [11:4] read_byte, [12] nack_seen, [13] cmd_rejected, [15:14] zero
   output logic [15:0] rsp_tdata
);

   logic          in_valid_ff;
   slot_req_type  in_data_ff;
   logic          out_valid_ff;
   slot_rsp_type  out_data_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   slot_rsp_type  res;
   logic          out_load;
   logic          advance;

   // Advance when the result register is free or being drained
   assign advance    = !out_valid_ff || rsp_tready;
   assign out_load   = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   i2cbs_slot u_slot (
      .state_cur (state_ff),
      .req       (in_data_ff),
      .state_nxt (state_in),
      .rsp       (res)
   );

   // Hold the request in the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_data_ff.cmd        <= req_tdata[2:0];
         in_data_ff.write_byte <= req_tdata[10:3];
         in_data_ff.sda_sample <= req_tdata[11];
      end
   end

   // Update sequencer state as each slot leaves for the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cmd      <= CMD_NONE;
         state_ff.slot     <= '0;
         state_ff.shift    <= '0;
         state_ff.scl_hold <= 1'b1;
         state_ff.sda_hold <= 1'b1;
      end else if (out_load) begin
         state_ff <= state_in;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
      if (out_load) begin
         out_data_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        out_data_ff.cmd_rejected,
                        out_data_ff.nack_seen,
                        out_data_ff.read_byte,
                        out_data_ff.done_res,
                        out_data_ff.busy_res,
                        out_data_ff.sda_level,
                        out_data_ff.scl_level};

   // Idle sequencer always sits at slot zero
   assert property (@(posedge clock) disable iff (reset)
      state_ff.cmd == CMD_NONE |-> state_ff.slot == '0)
      else $error("idle sequencer with nonzero slot");

   // Slot count never passes the acknowledge slot
   assert property (@(posedge clock) disable iff (reset)
      state_ff.slot <= ACK_SLOT)
      else $error("slot count out of range");

   // A finished command leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      out_load && res.done_res |=> state_ff.cmd == CMD_NONE)
      else $error("sequencer still busy after done");

   // Rejection only happens while a command runs
   assert property (@(posedge clock) disable iff (reset)
      out_load && res.cmd_rejected |-> state_ff.cmd != CMD_NONE && res.busy_res)
      else $error("command rejected while idle");

endmodule
`default_nettype wire
